// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared sizes, codes and transaction types of the binary max-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   // Heap sizing
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;

   // Request kinds
   localparam logic REQ_INSERT  = 1'b0;
   localparam logic REQ_EXTRACT = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Request transaction
   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] value;
   } heap_req_type;

   // Result transaction
   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      status_type               status;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] top_value;
   } heap_rsp_type;

endpackage

// ===== rtl/binary_max_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Priority queue of signed 32-bit values kept as a binary max-heap in RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel: one transaction either inserts req_data.value or extracts
//    the maximum. Every request produces exactly one rsp_* transaction.
//  - rsp_data carries the extracted value, a status (ok, empty, full), the
//    element count and the maximum left in the heap (0 when empty).
//  - One request is in progress at a time; req_stall is high from the cycle
//    after acceptance until the result has been written to the output register.
//  - An insert sifts up one level per cycle. An extract reads the last entry,
//    then the children of each level, left before right, through the single
//    RAM read port.
//  - The output register holds a result while rsp_stall is high; the next
//    request is still accepted and worked on, and only its result waits.
//  - Reset empties the heap (count to zero); RAM contents are not cleared and
//    need no clearing pass, since only entries below the count are read.
// ----------------------------------------------------------------------------
module binary_max_heap_queue
   import bmhq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  heap_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output heap_rsp_type rsp_data
);

   localparam int EXT_W = ADDR_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_LAST,
      ST_LEFT,
      ST_RIGHT,
      ST_PLACE,
      ST_RESP
   } state_type;

   // Parent index of a non-root heap slot
   function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] p);
      logic [ADDR_W-1:0] t;
      t = p - ADDR_W'(1);
      return t >> 1;
   endfunction

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] left_ff, left_in;
   logic signed [DATA_W-1:0] popped_ff, popped_in;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] top_ff;
   heap_rsp_type             rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     wr_en, rd_en;
   logic [ADDR_W-1:0]        wr_addr, rd_addr;
   logic signed [DATA_W-1:0] wr_data, rd_data;

   logic [EXT_W-1:0]         n_ext, cur_l_ext, cur_r_ext, desc_l_ext;
   logic                     has_r, desc_has_l;
   logic                     take_l, take_r, move;
   logic signed [DATA_W-1:0] cmp_val, child_val;
   logic [ADDR_W-1:0]        child_addr, desc_pos;
   logic [ADDR_W-1:0]        ins_pos, up_parent;
   logic [CNT_W-1:0]         cnt_dec;
   logic                     rsp_free;

   // Heap storage
   bmhq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Index arithmetic for both sift directions
   assign n_ext     = EXT_W'(count_ff);
   assign cur_l_ext = {1'b0, pos_ff, 1'b1};
   assign cur_r_ext = cur_l_ext + EXT_W'(1);
   assign has_r     = cur_r_ext < n_ext;
   assign ins_pos   = count_ff[ADDR_W-1:0];
   assign up_parent = parent_of(pos_ff);
   assign cnt_dec   = count_ff - CNT_W'(1);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Child choice: strictly greater only, left child wins a tie
   always_comb begin
      take_l     = left_ff > val_ff;
      cmp_val    = take_l ? left_ff : val_ff;
      take_r     = rd_data > cmp_val;
      move       = 1'b0;
      child_addr = cur_l_ext[ADDR_W-1:0];
      child_val  = rd_data;
      case (state_ff)
         ST_LEFT: begin
            move = rd_data > val_ff;
         end
         ST_RIGHT: begin
            move       = take_l || take_r;
            child_addr = take_r ? cur_r_ext[ADDR_W-1:0] : cur_l_ext[ADDR_W-1:0];
            child_val  = take_r ? rd_data : left_ff;
         end
         default: begin
            move = 1'b0;
         end
      endcase
      desc_pos   = (state_ff == ST_LAST) ? '0 : child_addr;
      desc_l_ext = {1'b0, desc_pos, 1'b1};
      desc_has_l = desc_l_ext < n_ext;
   end

   // Sequencer: read, compare and write back one heap level at a time
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      left_in      = left_ff;
      popped_in    = popped_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr      = desc_l_ext[ADDR_W-1:0];

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               popped_in = '0;
               status_in = STATUS_OK;
               state_in  = ST_RESP;
               if (req_data.req_type == REQ_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                     val_in   = req_data.value;
                     pos_in   = ins_pos;
                     if (ins_pos == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = req_data.value;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = parent_of(ins_pos);
                        state_in = ST_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     popped_in = top_ff;
                     count_in  = cnt_dec;
                     if (cnt_dec != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = cnt_dec[ADDR_W-1:0];
                        state_in = ST_LAST;
                     end
                  end
               end
            end
         end

         ST_UP: begin
            // rd_data holds the parent of pos
            if (val_ff > rd_data) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = up_parent;
               if (up_parent == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = parent_of(up_parent);
               end
            end else begin
               wr_en    = 1'b1;
               state_in = ST_RESP;
            end
         end

         ST_LAST: begin
            // rd_data holds the last element, now sifted from the root
            val_in = rd_data;
            pos_in = '0;
            if (desc_has_l) begin
               rd_en    = 1'b1;
               state_in = ST_LEFT;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = rd_data;
               state_in = ST_RESP;
            end
         end

         ST_LEFT, ST_RIGHT: begin
            if (state_ff == ST_LEFT && has_r) begin
               left_in  = rd_data;
               rd_en    = 1'b1;
               rd_addr  = cur_r_ext[ADDR_W-1:0];
               state_in = ST_RIGHT;
            end else if (move) begin
               wr_en   = 1'b1;
               wr_data = child_val;
               pos_in  = child_addr;
               if (desc_has_l) begin
                  rd_en    = 1'b1;
                  state_in = ST_LEFT;
               end else begin
                  state_in = ST_PLACE;
               end
            end else begin
               wr_en    = 1'b1;
               state_in = ST_RESP;
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_free) begin
               rsp_in.popped_value = popped_ff;
               rsp_in.status       = status_ff;
               rsp_in.count        = COUNT_W'(count_ff);
               rsp_in.top_value    = (count_ff != '0) ? top_ff : '0;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      left_ff   <= left_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
      // shadow of the root entry
      if (wr_en && wr_addr == '0) begin
         top_ff <= wr_data;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("heap count beyond capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write hit the same heap entry");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_EMPTY) |->
         (rsp_ff.count == '0 && rsp_ff.popped_value == '0))
      else $error("empty status with a non-empty heap");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_FULL) |->
         (rsp_ff.count == COUNT_W'(CAPACITY)))
      else $error("full status below capacity");

endmodule

// ===== rtl/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
